/* hdl/dap_pkg.sv */
// Shared constants, types and arithmetic helpers of the dihedral angle pipeline.
`timescale 1ns / 1ps

package dap_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int ANGLE_FRAC_DEF  = 13;

    // Angle accumulator: 24 fraction bits, pi fits well inside 28 signed bits.
    localparam int Z_FRAC       = 24;
    localparam int Z_W          = 28;
    localparam int CORDIC_STEPS = 24;

    // CORDIC x/y width: inputs below 2^30, the gain and the rotation stay below 2^32.
    localparam int XY_W = 34;

    // Shrink targets for the bond vectors and for the normals.
    localparam int SHRINK_HI = 30;
    localparam int SHRINK_LO = 20;
    localparam int SB_W      = SHRINK_HI + 1;
    localparam int SR_W      = SHRINK_LO + 1;

    // Normalized CORDIC input magnitude lies in [2^29, 2^30).
    localparam int NORM_BITS = 30;

    // Integer square root of |b2'|^2, which stays below 2^42.
    localparam int SQ_W       = 43;
    localparam int ROOT_STEPS = 21;

    localparam logic signed [Z_W-1:0] HALF_PI_Z = Z_W'(26353589);
    localparam int PI_Z_INT = 52707179;

    typedef logic signed [63:0] vec3_t [0:2];

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        mag64 = v[63] ? 64'(-v) : 64'(v);
    endfunction

    // Number of significant bits of an unsigned word.
    function automatic logic [6:0] blen64(input logic [63:0] m);
        logic [6:0] n;
        n = '0;
        for (int i = 0; i < 64; i++) begin
            if (m[i]) n = 7'(i + 1);
        end
        return n;
    endfunction

    // Scales a vector by a power of two so that its largest magnitude has at
    // most k bits; each component truncates toward zero.
    function automatic vec3_t shrink3(input vec3_t v, input int k);
        vec3_t       r;
        logic [63:0] m;
        logic [63:0] a;
        logic [6:0]  bl;
        logic [6:0]  s;
        m = '0;
        for (int i = 0; i < 3; i++) begin
            if (mag64(v[i]) > m) m = mag64(v[i]);
        end
        bl = blen64(m);
        s  = (int'(bl) > k) ? 7'(int'(bl) - k) : '0;
        for (int i = 0; i < 3; i++) begin
            a    = mag64(v[i]) >> s;
            r[i] = v[i][63] ? -$signed(a) : $signed(a);
        end
        return r;
    endfunction

    // atan(2^-i) with 24 fraction bits, rounded to nearest.
    function automatic logic signed [Z_W-1:0] atan_step(input int i);
        logic signed [Z_W-1:0] r;
        case (i)
            0:       r = Z_W'(13176795);
            1:       r = Z_W'(7778716);
            2:       r = Z_W'(4110060);
            3:       r = Z_W'(2086331);
            4:       r = Z_W'(1047214);
            5:       r = Z_W'(524117);
            6:       r = Z_W'(262123);
            7:       r = Z_W'(131069);
            default: r = Z_W'(1 << (Z_FRAC - i));
        endcase
        return r;
    endfunction

    // Largest output code: pi rounded to f fraction bits.
    function automatic int angle_lim(input int f);
        int sh;
        sh = Z_FRAC - f;
        return (PI_Z_INT + (1 << (sh - 1))) >>> sh;
    endfunction

endpackage

/* hdl/dihedral_angle_four_points.sv */
// Top level of the dihedral (torsion) angle pipeline for four 3-D points.
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// input     in_valid / in_ready    ax ay az bx by_coord bz cx cy cz dx dy dz
// output    out_valid / out_ready  angle degenerate
//
// One transaction enters per cycle while the pipeline advances, and each passes
// 58 register stages: 9 vector stages, 21 square root stages, 3 normalize
// stages, 24 CORDIC stages and the rounding stage that loads the output register.
// The whole pipeline advances together whenever the output register is empty
// or being taken, so a stall freezes every stage and nothing is lost.
// Reset clears only the valid bits; the data registers need no reset.

module dihedral_angle_four_points #(
    parameter int COORD_WIDTH     = dap_pkg::COORD_WIDTH_DEF,
    parameter int ANGLE_FRAC_BITS = dap_pkg::ANGLE_FRAC_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [COORD_WIDTH-1:0]   ax,
    input  logic signed [COORD_WIDTH-1:0]   ay,
    input  logic signed [COORD_WIDTH-1:0]   az,
    input  logic signed [COORD_WIDTH-1:0]   bx,
    input  logic signed [COORD_WIDTH-1:0]   by_coord,
    input  logic signed [COORD_WIDTH-1:0]   bz,
    input  logic signed [COORD_WIDTH-1:0]   cx,
    input  logic signed [COORD_WIDTH-1:0]   cy,
    input  logic signed [COORD_WIDTH-1:0]   cz,
    input  logic signed [COORD_WIDTH-1:0]   dx,
    input  logic signed [COORD_WIDTH-1:0]   dy,
    input  logic signed [COORD_WIDTH-1:0]   dz,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [ANGLE_FRAC_BITS+2:0] angle,
    output logic                            degenerate
);

    localparam int DW   = COORD_WIDTH + 1;
    localparam int AW   = ANGLE_FRAC_BITS + 3;
    localparam int SH   = dap_pkg::Z_FRAC - ANGLE_FRAC_BITS;
    localparam int SBW  = dap_pkg::SB_W;
    localparam int SRW  = dap_pkg::SR_W;
    localparam int XW   = dap_pkg::XY_W;
    localparam int ZW   = dap_pkg::Z_W;
    localparam int QW   = dap_pkg::SQ_W;
    localparam int SIDE_W = 1 + 43 + 64;
    localparam logic signed [ZW-1:0] LIM      = ZW'(dap_pkg::angle_lim(ANGLE_FRAC_BITS));
    localparam logic signed [ZW-1:0] HALF_LSB = ZW'(1) << (SH - 1);
    localparam logic [6:0]           NORM     = 7'(dap_pkg::NORM_BITS);

    logic out_valid_reg;
    logic signed [AW-1:0] angle_reg;
    logic degenerate_reg;

    // Every stage moves when the output register can take a new result.
    logic adv;
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg, v9_reg;
    logic v10_reg, v11_reg, v12_reg;

    // Stage 1: bond vectors b1 = B - A, b2 = C - B, b3 = D - C.
    logic signed [DW-1:0] b1_reg [3];
    logic signed [DW-1:0] b2_reg [3];
    logic signed [DW-1:0] b3_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b1_reg[0] <= DW'(bx) - DW'(ax);
            b1_reg[1] <= DW'(by_coord) - DW'(ay);
            b1_reg[2] <= DW'(bz) - DW'(az);
            b2_reg[0] <= DW'(cx) - DW'(bx);
            b2_reg[1] <= DW'(cy) - DW'(by_coord);
            b2_reg[2] <= DW'(cz) - DW'(bz);
            b3_reg[0] <= DW'(dx) - DW'(cx);
            b3_reg[1] <= DW'(dy) - DW'(cy);
            b3_reg[2] <= DW'(dz) - DW'(cz);
        end
    end

    // Stage 2: the bond vectors are shrunk to 30-bit magnitudes, which only
    // changes anything for very wide coordinates.
    dap_pkg::vec3_t w1, w2, w3, r1, r2, r3;
    logic signed [SBW-1:0] sb1_reg [3];
    logic signed [SBW-1:0] sb2_reg [3];
    logic signed [SBW-1:0] sb3_reg [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            w1[k] = 64'(b1_reg[k]);
            w2[k] = 64'(b2_reg[k]);
            w3[k] = 64'(b3_reg[k]);
        end
        r1 = dap_pkg::shrink3(w1, dap_pkg::SHRINK_HI);
        r2 = dap_pkg::shrink3(w2, dap_pkg::SHRINK_HI);
        r3 = dap_pkg::shrink3(w3, dap_pkg::SHRINK_HI);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                sb1_reg[k] <= SBW'(r1[k]);
                sb2_reg[k] <= SBW'(r2[k]);
                sb3_reg[k] <= SBW'(r3[k]);
            end
        end
    end

    // Stage 3: the twelve partial products of the normals n1 = b1 x b2 and
    // n2 = b2 x b3.
    logic signed [61:0] p_reg [12];
    logic signed [SBW-1:0] b2c_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg[0]  <= 62'(sb1_reg[1]) * 62'(sb2_reg[2]);
            p_reg[1]  <= 62'(sb1_reg[2]) * 62'(sb2_reg[1]);
            p_reg[2]  <= 62'(sb1_reg[2]) * 62'(sb2_reg[0]);
            p_reg[3]  <= 62'(sb1_reg[0]) * 62'(sb2_reg[2]);
            p_reg[4]  <= 62'(sb1_reg[0]) * 62'(sb2_reg[1]);
            p_reg[5]  <= 62'(sb1_reg[1]) * 62'(sb2_reg[0]);
            p_reg[6]  <= 62'(sb2_reg[1]) * 62'(sb3_reg[2]);
            p_reg[7]  <= 62'(sb2_reg[2]) * 62'(sb3_reg[1]);
            p_reg[8]  <= 62'(sb2_reg[2]) * 62'(sb3_reg[0]);
            p_reg[9]  <= 62'(sb2_reg[0]) * 62'(sb3_reg[2]);
            p_reg[10] <= 62'(sb2_reg[0]) * 62'(sb3_reg[1]);
            p_reg[11] <= 62'(sb2_reg[1]) * 62'(sb3_reg[0]);
            b2c_reg   <= sb2_reg;
        end
    end

    // Stage 4: the normals themselves.
    logic signed [62:0] n1_reg [3];
    logic signed [62:0] n2_reg [3];
    logic signed [SBW-1:0] b2d_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                n1_reg[k] <= 63'(p_reg[2*k]) - 63'(p_reg[2*k+1]);
                n2_reg[k] <= 63'(p_reg[6+2*k]) - 63'(p_reg[7+2*k]);
            end
            b2d_reg <= b2c_reg;
        end
    end

    // Stage 5: degenerate geometry is detected, and n1, n2 and b2 are shrunk
    // to 20-bit magnitudes so the remaining products stay narrow.
    dap_pkg::vec3_t u1, u2, u3, t1, t2, t3;
    logic degen5;
    logic signed [SRW-1:0] m1_reg [3];
    logic signed [SRW-1:0] m2_reg [3];
    logic signed [SRW-1:0] mb_reg [3];
    logic degen5_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            u1[k] = 64'(n1_reg[k]);
            u2[k] = 64'(n2_reg[k]);
            u3[k] = 64'(b2d_reg[k]);
        end
        t1 = dap_pkg::shrink3(u1, dap_pkg::SHRINK_LO);
        t2 = dap_pkg::shrink3(u2, dap_pkg::SHRINK_LO);
        t3 = dap_pkg::shrink3(u3, dap_pkg::SHRINK_LO);
        degen5 = (b2d_reg[0] == '0 && b2d_reg[1] == '0 && b2d_reg[2] == '0)
              || (n1_reg[0] == '0 && n1_reg[1] == '0 && n1_reg[2] == '0)
              || (n2_reg[0] == '0 && n2_reg[1] == '0 && n2_reg[2] == '0);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                m1_reg[k] <= SRW'(t1[k]);
                m2_reg[k] <= SRW'(t2[k]);
                mb_reg[k] <= SRW'(t3[k]);
            end
            degen5_reg <= degen5;
        end
    end

    // Stage 6: products for c = n1' x n2', for n1'.n2' and for |b2'|^2.
    logic signed [41:0] q_reg [6];
    logic signed [41:0] d_reg [3];
    logic signed [41:0] s_reg [3];
    logic signed [SRW-1:0] mb6_reg [3];
    logic degen6_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q_reg[0] <= 42'(m1_reg[1]) * 42'(m2_reg[2]);
            q_reg[1] <= 42'(m1_reg[2]) * 42'(m2_reg[1]);
            q_reg[2] <= 42'(m1_reg[2]) * 42'(m2_reg[0]);
            q_reg[3] <= 42'(m1_reg[0]) * 42'(m2_reg[2]);
            q_reg[4] <= 42'(m1_reg[0]) * 42'(m2_reg[1]);
            q_reg[5] <= 42'(m1_reg[1]) * 42'(m2_reg[0]);
            for (int k = 0; k < 3; k++)
            begin
                d_reg[k] <= 42'(m1_reg[k]) * 42'(m2_reg[k]);
                s_reg[k] <= 42'(mb_reg[k]) * 42'(mb_reg[k]);
            end
            mb6_reg    <= mb_reg;
            degen6_reg <= degen5_reg;
        end
    end

    // Stage 7: c, the dot product of the normals and the squared length.
    logic signed [41:0] c_reg [3];
    logic signed [42:0] dot7_reg;
    logic [QW-1:0] sq7_reg;
    logic signed [SRW-1:0] mb7_reg [3];
    logic degen7_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                c_reg[k] <= q_reg[2*k] - q_reg[2*k+1];
            end
            dot7_reg   <= 43'(d_reg[0]) + 43'(d_reg[1]) + 43'(d_reg[2]);
            sq7_reg    <= QW'(s_reg[0]) + QW'(s_reg[1]) + QW'(s_reg[2]);
            mb7_reg    <= mb6_reg;
            degen7_reg <= degen6_reg;
        end
    end

    // Stages 8 and 9: y = c . b2'.
    logic signed [62:0] yp_reg [3];
    logic signed [42:0] dot8_reg;
    logic [QW-1:0] sq8_reg;
    logic degen8_reg;
    logic signed [63:0] y9_reg;
    logic signed [42:0] dot9_reg;
    logic [QW-1:0] sq9_reg;
    logic degen9_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                yp_reg[k] <= 63'(c_reg[k]) * 63'(mb7_reg[k]);
            end
            dot8_reg   <= dot7_reg;
            sq8_reg    <= sq7_reg;
            degen8_reg <= degen7_reg;
            y9_reg     <= 64'(yp_reg[0]) + 64'(yp_reg[1]) + 64'(yp_reg[2]);
            dot9_reg   <= dot8_reg;
            sq9_reg    <= sq8_reg;
            degen9_reg <= degen8_reg;
        end
    end

    // Square root of |b2'|^2; the dot product, y and the flag ride along.
    logic sq_valid;
    logic [QW-1:0] root;
    logic [SIDE_W-1:0] sq_side;

    dap_isqrt #(
        .SIDE_W (SIDE_W)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v9_reg),
        .n_in      (sq9_reg),
        .side_in   ({degen9_reg, dot9_reg, y9_reg}),
        .out_valid (sq_valid),
        .root      (root),
        .side_out  (sq_side)
    );

    // Stage 10: x = (n1'.n2') * isqrt(|b2'|^2).
    logic signed [63:0] x10_reg;
    logic signed [63:0] y10_reg;
    logic degen10_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x10_reg     <= 64'($signed(sq_side[106:64])) * 64'($signed({1'b0, root[21:0]}));
            y10_reg     <= sq_side[63:0];
            degen10_reg <= sq_side[107];
        end
    end

    // Stage 11: magnitudes, signs and the bit length of the larger one.
    logic [63:0] xm_reg, ym_reg;
    logic xneg_reg, yneg_reg;
    logic [6:0] bl_reg;
    logic zero11_reg;
    logic degen11_reg;
    logic [63:0] xm11, ym11, mx11;

    always_comb
    begin
        xm11 = dap_pkg::mag64(x10_reg);
        ym11 = dap_pkg::mag64(y10_reg);
        mx11 = (xm11 > ym11) ? xm11 : ym11;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xm_reg      <= xm11;
            ym_reg      <= ym11;
            xneg_reg    <= x10_reg[63];
            yneg_reg    <= y10_reg[63];
            bl_reg      <= dap_pkg::blen64(mx11);
            zero11_reg  <= (mx11 == '0);
            degen11_reg <= degen10_reg;
        end
    end

    // Stage 12: x and y are scaled together so the larger magnitude lands in
    // [2^29, 2^30), then the left half plane is rotated by a quarter turn.
    logic [63:0] xs12, ys12;
    logic signed [XW-1:0] xn12, yn12, xq12, yq12;
    logic signed [ZW-1:0] zq12;
    logic signed [XW-1:0] xc_reg, yc_reg;
    logic signed [ZW-1:0] zc_reg;
    logic [1:0] flags12_reg;

    always_comb
    begin
        if (bl_reg > NORM)
        begin
            xs12 = xm_reg >> (bl_reg - NORM);
            ys12 = ym_reg >> (bl_reg - NORM);
        end
        else
        begin
            xs12 = xm_reg << (NORM - bl_reg);
            ys12 = ym_reg << (NORM - bl_reg);
        end
        xn12 = xneg_reg ? -$signed(XW'(xs12)) : $signed(XW'(xs12));
        yn12 = yneg_reg ? -$signed(XW'(ys12)) : $signed(XW'(ys12));
        if (xn12[XW-1] && !yn12[XW-1])
        begin
            xq12 = yn12;
            yq12 = -xn12;
            zq12 = dap_pkg::HALF_PI_Z;
        end
        else if (xn12[XW-1])
        begin
            xq12 = -yn12;
            yq12 = xn12;
            zq12 = -dap_pkg::HALF_PI_Z;
        end
        else
        begin
            xq12 = xn12;
            yq12 = yn12;
            zq12 = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xc_reg      <= xq12;
            yc_reg      <= yq12;
            zc_reg      <= zq12;
            flags12_reg <= {degen11_reg, zero11_reg};
        end
    end

    // CORDIC: 24 rotations drive y toward zero and sum the angle in z.
    logic cv;
    logic signed [ZW-1:0] zf;
    logic [1:0] cflags;

    dap_cordic #(
        .SIDE_W (2)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v12_reg),
        .x_in      (xc_reg),
        .y_in      (yc_reg),
        .z_in      (zc_reg),
        .side_in   (flags12_reg),
        .out_valid (cv),
        .z_out     (zf),
        .side_out  (cflags)
    );

    // Final stage: round half up to the output precision and clamp to pi.
    // A degenerate item, or one with both CORDIC inputs zero, reads as 0.
    logic signed [ZW-1:0] zr;
    logic signed [ZW-1:0] zl;

    always_comb
    begin
        zr = (zf + HALF_LSB) >>> SH;
        if (cflags[1] || cflags[0])
            zl = '0;
        else if (zr > LIM)
            zl = LIM;
        else if (zr < -LIM)
            zl = -LIM;
        else
            zl = zr;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            angle_reg      <= AW'(zl);
            degenerate_reg <= cflags[1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            v7_reg        <= 1'b0;
            v8_reg        <= 1'b0;
            v9_reg        <= 1'b0;
            v10_reg       <= 1'b0;
            v11_reg       <= 1'b0;
            v12_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            v6_reg        <= v5_reg;
            v7_reg        <= v6_reg;
            v8_reg        <= v7_reg;
            v9_reg        <= v8_reg;
            v10_reg       <= sq_valid;
            v11_reg       <= v10_reg;
            v12_reg       <= v11_reg;
            out_valid_reg <= cv;
        end
    end

    assign out_valid  = out_valid_reg;
    assign angle      = angle_reg;
    assign degenerate = degenerate_reg;

endmodule

/* hdl/dap_isqrt.sv */
// Pipelined integer square root, one result bit per stage, with a sideband payload.
`timescale 1ns / 1ps

module dap_isqrt #(
    parameter int SIDE_W = 1,
    parameter int N_W    = dap_pkg::SQ_W,
    parameter int STEPS  = dap_pkg::ROOT_STEPS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [N_W-1:0]    n_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [N_W-1:0]    root,
    output logic [SIDE_W-1:0] side_out
);

    logic [N_W-1:0]    n_reg    [1:STEPS-1];
    logic [N_W-1:0]    r_reg    [1:STEPS];
    logic [SIDE_W-1:0] side_reg [1:STEPS];
    logic              v_reg    [1:STEPS];

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        localparam logic [N_W-1:0] BIT = N_W'(1) << (2 * (STEPS - 1 - i));

        logic [N_W-1:0]    n_cur;
        logic [N_W-1:0]    r_cur;
        logic [SIDE_W-1:0] s_cur;
        logic              v_cur;
        logic [N_W-1:0]    trial;
        logic              take;

        if (i == 0) begin : g_first
            assign n_cur = n_in;
            assign r_cur = '0;
            assign s_cur = side_in;
            assign v_cur = in_valid;
        end else begin : g_next
            assign n_cur = n_reg[i];
            assign r_cur = r_reg[i];
            assign s_cur = side_reg[i];
            assign v_cur = v_reg[i];
        end

        assign trial = r_cur + BIT;
        assign take  = (n_cur >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[i+1]    <= take ? (r_cur >> 1) + BIT : r_cur >> 1;
                side_reg[i+1] <= s_cur;
            end
        end

        if (i < STEPS - 1) begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    n_reg[i+1] <= take ? n_cur - trial : n_cur;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i+1] <= v_cur;
            end
        end
    end

    assign out_valid = v_reg[STEPS];
    assign root      = r_reg[STEPS];
    assign side_out  = side_reg[STEPS];

endmodule

/* hdl/dap_cordic.sv */
// Pipelined CORDIC arctangent in vectoring mode, one rotation per stage.
`timescale 1ns / 1ps

module dap_cordic #(
    parameter int SIDE_W = 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [dap_pkg::XY_W-1:0]   x_in,
    input  logic signed [dap_pkg::XY_W-1:0]   y_in,
    input  logic signed [dap_pkg::Z_W-1:0]    z_in,
    input  logic [SIDE_W-1:0]                 side_in,
    output logic                              out_valid,
    output logic signed [dap_pkg::Z_W-1:0]    z_out,
    output logic [SIDE_W-1:0]                 side_out
);

    localparam int N  = dap_pkg::CORDIC_STEPS;
    localparam int XW = dap_pkg::XY_W;
    localparam int ZW = dap_pkg::Z_W;

    logic signed [XW-1:0] x_reg    [1:N-1];
    logic signed [XW-1:0] y_reg    [1:N-1];
    logic signed [ZW-1:0] z_reg    [1:N];
    logic [SIDE_W-1:0]    side_reg [1:N];
    logic                 v_reg    [1:N];

    for (genvar i = 0; i < N; i++) begin : g_rot
        localparam logic signed [ZW-1:0] ATAN = dap_pkg::atan_step(i);

        logic signed [XW-1:0] x_cur;
        logic signed [XW-1:0] y_cur;
        logic signed [ZW-1:0] z_cur;
        logic [SIDE_W-1:0]    s_cur;
        logic                 v_cur;

        if (i == 0) begin : g_first
            assign x_cur = x_in;
            assign y_cur = y_in;
            assign z_cur = z_in;
            assign s_cur = side_in;
            assign v_cur = in_valid;
        end else begin : g_next
            assign x_cur = x_reg[i];
            assign y_cur = y_reg[i];
            assign z_cur = z_reg[i];
            assign s_cur = side_reg[i];
            assign v_cur = v_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                z_reg[i+1]    <= y_cur[XW-1] ? z_cur - ATAN : z_cur + ATAN;
                side_reg[i+1] <= s_cur;
            end
        end

        if (i < N - 1) begin : g_xy
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (y_cur[XW-1])
                    begin
                        x_reg[i+1] <= x_cur - (y_cur >>> i);
                        y_reg[i+1] <= y_cur + (x_cur >>> i);
                    end
                    else
                    begin
                        x_reg[i+1] <= x_cur + (y_cur >>> i);
                        y_reg[i+1] <= y_cur - (x_cur >>> i);
                    end
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i+1] <= v_cur;
            end
        end
    end

    assign out_valid = v_reg[N];
    assign z_out     = z_reg[N];
    assign side_out  = side_reg[N];

endmodule

/* hdl/dap_checker.sv */
// Port-level checks of the dihedral angle block and the bind that attaches them.
`timescale 1ns / 1ps

module dap_checker #(
    parameter int ANGLE_FRAC_BITS = dap_pkg::ANGLE_FRAC_DEF
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic signed [ANGLE_FRAC_BITS+2:0] angle,
    input logic                              degenerate
);

    localparam int LIM = dap_pkg::angle_lim(ANGLE_FRAC_BITS);

    // A waiting result holds its value until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(angle) && $stable(degenerate))
        else $error("result changed while stalled");

    // A degenerate result always carries a zero angle.
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> angle == '0)
        else $error("degenerate result with nonzero angle");

    // The angle never leaves the range of minus pi to pi.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (angle <= LIM) && (angle >= -LIM))
        else $error("angle outside minus pi to pi");

    // The input side is open whenever the output side can move.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid || out_ready |-> in_ready)
        else $error("input stalled while output free");

endmodule

bind dihedral_angle_four_points dap_checker #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
) u_dap_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .angle      (angle),
    .degenerate (degenerate)
);
